// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file crrm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/crrm_pkg.sv -----
// Types, constants and helpers of the record ring manager.
`default_nettype none
package crrm_pkg;

  localparam int RING_LINES = 1024;
  localparam int IDX_W      = $clog2(RING_LINES);
  localparam int LINES_W    = 11;
  localparam int BYTES_W    = 17;
  localparam int HDR_W      = BYTES_W + LINES_W;
  localparam int OP_W       = 2;
  localparam int STS_W      = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic CFG_IDX_LINES_IN_USE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_FETCH   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FAIL = 2'd1,
    STS_NONE = 2'd2
  } sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HDR,
    ST_RD2
  } state_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic exec;
    logic hdr;
    logic rd2;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic alloc_wrap;
    logic fetch_retry;
  } dp_sts_t;

  // Ring size from the register: out of range means full depth, else round down
  // to a power of two.
  function automatic logic [LINES_W-1:0] ring_size_of(input logic [LINES_W-1:0] v);
    logic [LINES_W-1:0] p;
    p = LINES_W'(RING_LINES);
    if (v != '0 && v <= LINES_W'(RING_LINES)) begin
      p = '0;
      for (int i = 0; i < LINES_W; i++) begin
        if (v[i]) p = LINES_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- sv/crrm_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module crrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/crrm_ctrl.sv -----
// Operation sequencer of the record ring manager.
`default_nettype none
module crrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  crrm_pkg::dp_sts_t st,
  output crrm_pkg::cmd_t    cmd,
  output logic              busy
);
  import crrm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (st.op == OP_ALLOC && st.alloc_wrap) begin
          state_next = ST_HDR;
        end else if (st.op == OP_FETCH && st.fetch_retry) begin
          state_next = ST_RD2;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HDR:  state_next = ST_IDLE;
      ST_RD2:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        cmd.load = start;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_HDR:  cmd.hdr  = 1'b1;
      ST_RD2:  cmd.rd2  = 1'b1;
      default: cmd = '0;
    endcase
    busy = !cmd.idle;
  end

endmodule
`default_nettype wire

// ----- sv/crrm_dp.sv -----
// Positions, header store, config register and result registers.
`default_nettype none
module crrm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  crrm_pkg::cmd_t                cmd,
  output crrm_pkg::dp_sts_t             st,
  input  logic [crrm_pkg::OP_W-1:0]     op,
  input  logic [crrm_pkg::BYTES_W-1:0]  byte_count,
  input  logic [crrm_pkg::LINES_W-1:0]  line_count,
  output logic                          done,
  output logic [crrm_pkg::STS_W-1:0]    status,
  output logic [crrm_pkg::IDX_W-1:0]    line_index,
  output logic [crrm_pkg::BYTES_W-1:0]  record_bytes,
  input  logic                          cfg_wr,
  input  logic                          cfg_sel,
  input  logic [crrm_pkg::DATA_W-1:0]   cfg_wdata,
  output logic [crrm_pkg::DATA_W-1:0]   cfg_rdata
);
  import crrm_pkg::*;

  logic [LINES_W-1:0] lines_in_use, lines_in_use_next;
  logic [LINES_W-1:0] ring_size, ring_size_next;
  logic [LINES_W-1:0] write_pos, write_pos_next;
  logic [IDX_W-1:0]   read_pos, read_pos_next;
  logic [LINES_W-1:0] free_run, free_run_next;
  logic [LINES_W-1:0] pend_w, pend_w_next;
  logic [LINES_W-1:0] pend_r, pend_r_next;
  op_t                op_q, op_q_next;
  logic [BYTES_W-1:0] bytes_q, bytes_q_next;
  logic [LINES_W-1:0] lines_q, lines_q_next;
  logic               done_next;
  logic [STS_W-1:0]   status_next;
  logic [IDX_W-1:0]   line_index_next;
  logic [BYTES_W-1:0] record_bytes_next;

  logic               ram_en, ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [HDR_W-1:0]   ram_wdata, ram_rdata;
  logic [BYTES_W-1:0] rd_bytes;
  logic [LINES_W-1:0] rd_lines;

  logic [LINES_W-1:0] r_ext, right, left, fr_ref, wp_ref, fr_new, wp_new, w_eff;
  logic [LINES_W-1:0] cfg_size;
  logic               wrap, need_refresh, alloc_ok, mark_wr, found;

  function automatic logic [IDX_W-1:0] ring_size_m1(input logic [LINES_W-1:0] sz);
    logic [LINES_W-1:0] m;
    m = sz - LINES_W'(1);
    return m[IDX_W-1:0];
  endfunction

  crrm_ram #(
    .WIDTH (HDR_W),
    .DEPTH (RING_LINES)
  ) u_hdr_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_bytes = ram_rdata[HDR_W-1:LINES_W];
  assign rd_lines = ram_rdata[LINES_W-1:0];
  assign found    = rd_bytes != '0;
  assign cfg_size = ring_size_of(cfg_wdata[LINES_W-1:0]);

  // free-run refresh for a write alloc
  always_comb begin
    r_ext  = {{(LINES_W-IDX_W){1'b0}}, read_pos};
    right  = ring_size - write_pos;
    left   = r_ext - LINES_W'(1);
    fr_ref = free_run;
    wp_ref = write_pos;
    wrap   = 1'b0;
    if (r_ext > write_pos) begin
      fr_ref = r_ext - write_pos - LINES_W'(1);
    end else if (r_ext != '0) begin
      if (right >= lines_q) begin
        fr_ref = right;
      end else if (left >= lines_q) begin
        wrap   = 1'b1;
        wp_ref = '0;
        fr_ref = left;
      end
    end else if (write_pos != ring_size) begin
      fr_ref = ring_size - write_pos - LINES_W'(1);
    end
    need_refresh = free_run < lines_q;
    fr_new   = need_refresh ? fr_ref : free_run;
    wp_new   = need_refresh ? wp_ref : write_pos;
    alloc_ok = lines_q != '0 && fr_new >= lines_q;
    mark_wr  = lines_q != '0 && need_refresh && wrap && right != '0;
    w_eff    = (write_pos == ring_size) ? '0 : write_pos;
  end

  always_comb begin
    st.op          = op_q;
    st.alloc_wrap  = mark_wr;
    st.fetch_retry = w_eff != r_ext && !found && write_pos != '0;
  end

  always_comb begin
    lines_in_use_next = lines_in_use;
    ring_size_next    = ring_size;
    write_pos_next    = write_pos;
    read_pos_next     = read_pos;
    free_run_next     = free_run;
    pend_w_next       = pend_w;
    pend_r_next       = pend_r;
    op_q_next         = op_q;
    bytes_q_next      = bytes_q;
    lines_q_next      = lines_q;
    done_next         = 1'b0;
    status_next       = status;
    line_index_next   = line_index;
    record_bytes_next = record_bytes;
    ram_en            = 1'b0;
    ram_we            = 1'b0;
    ram_addr          = read_pos;
    ram_wdata         = '0;

    if (cmd.idle) begin
      ram_en   = 1'b1;
      ram_addr = cfg_wr ? '0 : read_pos;
    end

    if (cmd.load) begin
      op_q_next    = op_t'(op);
      bytes_q_next = byte_count;
      lines_q_next = line_count;
    end

    if (cmd.exec) begin
      case (op_q)
        OP_ALLOC: begin
          pend_w_next    = alloc_ok ? lines_q : '0;
          free_run_next  = fr_new;
          write_pos_next = wp_new;
          if (mark_wr) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = write_pos[IDX_W-1:0];
            ram_wdata = '0;
          end else begin
            if (alloc_ok) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = wp_new[IDX_W-1:0];
              ram_wdata = {bytes_q, lines_q};
            end
            done_next         = 1'b1;
            status_next       = alloc_ok ? STS_OK : STS_FAIL;
            line_index_next   = alloc_ok ? wp_new[IDX_W-1:0] : '0;
            record_bytes_next = '0;
          end
        end
        OP_COMMIT: begin
          done_next         = 1'b1;
          record_bytes_next = '0;
          if (pend_w == '0) begin
            status_next     = STS_NONE;
            line_index_next = '0;
          end else begin
            status_next     = STS_OK;
            line_index_next = write_pos[IDX_W-1:0];
            free_run_next   = (free_run >= pend_w) ? free_run - pend_w : '0;
            write_pos_next  = write_pos + pend_w;
            pend_w_next     = '0;
          end
        end
        OP_FETCH: begin
          pend_r_next = '0;
          if (w_eff != r_ext && found) begin
            done_next         = 1'b1;
            status_next       = STS_OK;
            line_index_next   = read_pos;
            record_bytes_next = rd_bytes;
            pend_r_next       = rd_lines;
          end else if (w_eff != r_ext && write_pos != '0) begin
            read_pos_next = '0;
            ram_en        = 1'b1;
            ram_addr      = '0;
          end else begin
            done_next         = 1'b1;
            status_next       = STS_FAIL;
            line_index_next   = '0;
            record_bytes_next = '0;
          end
        end
        OP_RELEASE: begin
          done_next         = 1'b1;
          record_bytes_next = '0;
          if (pend_r == '0) begin
            status_next     = STS_NONE;
            line_index_next = '0;
          end else begin
            status_next     = STS_OK;
            line_index_next = read_pos;
            read_pos_next   = (read_pos + pend_r[IDX_W-1:0])
                              & ring_size_m1(ring_size);
            pend_r_next     = '0;
          end
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end

    // header write after the wrap marker
    if (cmd.hdr) begin
      ram_en            = 1'b1;
      ram_we            = 1'b1;
      ram_addr          = '0;
      ram_wdata         = {bytes_q, lines_q};
      done_next         = 1'b1;
      status_next       = STS_OK;
      line_index_next   = '0;
      record_bytes_next = '0;
    end

    // second look after skipping a wrap marker
    if (cmd.rd2) begin
      done_next       = 1'b1;
      line_index_next = '0;
      if (found) begin
        status_next       = STS_OK;
        record_bytes_next = rd_bytes;
        pend_r_next       = rd_lines;
      end else begin
        status_next       = STS_FAIL;
        record_bytes_next = '0;
      end
    end

    if (cfg_wr) begin
      lines_in_use_next = cfg_wdata[LINES_W-1:0];
      ring_size_next    = cfg_size;
      write_pos_next    = '0;
      read_pos_next     = '0;
      free_run_next     = cfg_size - LINES_W'(1);
      pend_w_next       = '0;
      pend_r_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_in_use <= LINES_W'(RING_LINES);
      ring_size    <= LINES_W'(RING_LINES);
      write_pos    <= '0;
      read_pos     <= '0;
      free_run     <= LINES_W'(RING_LINES - 1);
      pend_w       <= '0;
      pend_r       <= '0;
      done         <= 1'b0;
    end else begin
      lines_in_use <= lines_in_use_next;
      ring_size    <= ring_size_next;
      write_pos    <= write_pos_next;
      read_pos     <= read_pos_next;
      free_run     <= free_run_next;
      pend_w       <= pend_w_next;
      pend_r       <= pend_r_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q         <= op_q_next;
    bytes_q      <= bytes_q_next;
    lines_q      <= lines_q_next;
    status       <= status_next;
    line_index   <= line_index_next;
    record_bytes <= record_bytes_next;
  end

  assign cfg_rdata = (cfg_sel == CFG_IDX_LINES_IN_USE)
                     ? {{(DATA_W-LINES_W){1'b0}}, lines_in_use} : '0;

endmodule
`default_nettype wire

// ----- sv/contiguous_record_ring_manager_core.sv -----
// Top level of the contiguous record ring manager.
// Ring of header lines holding variable-length records in contiguous runs. Pulse
// start while busy is low with op (0 write alloc, 1 write commit, 2 read fetch,
// 3 read release), byte_count and line_count; exactly one result word follows,
// shown on status, line_index and record_bytes for the single cycle that done is
// high. The receiver cannot stall: capture the word when done is seen. An op is
// taken while idle and run in the exec state; an alloc that wraps and leaves a
// zero marker adds a header write state, a fetch that skips a marker a second
// read state. The header RAM is single-port with registered read, one access
// per cycle; a fetch's header read is issued while idle. Header lines are not
// cleared after reset; only fetch positions that were written hold meaningful
// data. Write lines_in_use (APB address 0) only while idle; it empties the ring.
`default_nettype none
module contiguous_record_ring_manager_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [crrm_pkg::OP_W-1:0]     op,
  input  logic [crrm_pkg::BYTES_W-1:0]  byte_count,
  input  logic [crrm_pkg::LINES_W-1:0]  line_count,
  output logic                          done,
  output logic [crrm_pkg::STS_W-1:0]    status,
  output logic [crrm_pkg::IDX_W-1:0]    line_index,
  output logic [crrm_pkg::BYTES_W-1:0]  record_bytes,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [crrm_pkg::DATA_W-1:0]   pwdata,
  output logic [crrm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import crrm_pkg::*;

  cmd_t    cmd;
  dp_sts_t st;
  logic    cfg_wr;
  logic    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready
                   && cfg_sel == CFG_IDX_LINES_IN_USE;

  crrm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  crrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .op           (op),
    .byte_count   (byte_count),
    .line_count   (line_count),
    .done         (done),
    .status       (status),
    .line_index   (line_index),
    .record_bytes (record_bytes),
    .cfg_wr       (cfg_wr),
    .cfg_sel      (cfg_sel),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata)
  );

endmodule
`default_nettype wire

// ----- sv/crrm_checker.sv -----
// Port-level checks of the record ring manager, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module crrm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [crrm_pkg::STS_W-1:0]    status,
  input logic [crrm_pkg::IDX_W-1:0]    line_index,
  input logic [crrm_pkg::BYTES_W-1:0]  record_bytes
);
  import crrm_pkg::*;

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held longer than one cycle")
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy, "result word while still busy")
  `ASSERT_IMPLY(a_fail_clean, clk, rst, done && status != STS_OK, line_index == '0 && record_bytes == '0, "failed word carries data")

endmodule

bind contiguous_record_ring_manager_core crrm_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .line_index   (line_index),
  .record_bytes (record_bytes)
);
`default_nettype wire
